// ----- sv/isc_pkg.sv -----
`timescale 1ns / 1ps

package isc_pkg;

	localparam int unsigned MAX_SEGMENTS = 256;
	localparam int unsigned MAX_QUERIES  = 65536;

	// stored count runs 0..MAX_SEGMENTS inclusive
	localparam int unsigned SEG_CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam int unsigned QRY_CNT_W = $clog2(MAX_QUERIES);
	localparam int unsigned COVER_W   = 9;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_QUERY = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] seg_start;
		logic signed [31:0] seg_end;
		logic signed [31:0] point;
	} request_t;

	typedef struct packed {
		logic [COVER_W-1:0] cover_count;
		logic [15:0]        point_index;
		logic               overflowed;
	} result_t;

	typedef struct packed {
		logic signed [31:0] seg_start;
		logic signed [31:0] seg_end;
	} segment_t;

	// query token travelling down the cell row
	typedef struct packed {
		logic                 valid;
		logic signed [31:0]   point;
		logic [SEG_CNT_W-1:0] remaining;
		logic [COVER_W-1:0]   hits;
	} token_t;

endpackage

// ----- sv/isc_cell.sv -----
`timescale 1ns / 1ps

module isc_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift_en,
	input  isc_pkg::segment_t seg_in,
	output isc_pkg::segment_t seg_out,
	input  isc_pkg::token_t   tok_in,
	output isc_pkg::token_t   tok_out
);

	isc_pkg::segment_t seg_q;
	isc_pkg::token_t   tok_q;
	isc_pkg::token_t   tok_next;
	logic              occupied;
	logic              hit;

	// cells below the stored count hold live segments
	assign occupied = (tok_in.remaining != '0);
	assign hit = tok_in.valid && occupied
		&& (seg_q.seg_start <= tok_in.point) && (tok_in.point <= seg_q.seg_end);

	always_comb begin
		tok_next = tok_in;
		if (occupied) begin
			tok_next.remaining = tok_in.remaining - 1'b1;
		end
		if (hit && (tok_in.hits != '1)) begin
			tok_next.hits = tok_in.hits + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			seg_q <= seg_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_next;
		end
	end

	assign seg_out = seg_q;
	assign tok_out = tok_q;

endmodule

// ----- sv/interval_stabbing_counter.sv -----
`timescale 1ns / 1ps

// interval stabbing counter: keeps up to MAX_SEGMENTS closed segments and, for each
// query item, counts those that contain the point. clear and load items never raise
// busy. a query item travels down a row of MAX_SEGMENTS compare cells, one cell per
// cycle, and its result appears on done when the token is held in the last cell; busy
// stays high until the cycle after done, so no new item is taken while a query is
// in flight, and the row length sets how long it holds busy. done is a single-cycle
// strobe and the receiver cannot stall it, so the result must be captured in the
// cycle it is shown. reversed segments (start above end) are dropped silently; loads
// into a full store are dropped and set the sticky overflow bit, which only a clear
// item or reset clears.

module interval_stabbing_counter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  isc_pkg::request_t request,
	output logic              done,
	output isc_pkg::result_t  result
);

	localparam int unsigned N = isc_pkg::MAX_SEGMENTS;

	logic                          accept;
	logic                          load_ok;
	logic                          query_go;
	logic [isc_pkg::SEG_CNT_W-1:0] stored_q;
	logic [isc_pkg::QRY_CNT_W-1:0] query_q;
	logic [15:0]                   qidx_q;
	logic                          ovf_q;
	logic                          busy_q;

	isc_pkg::segment_t seg_new;
	isc_pkg::token_t   tok_new;
	isc_pkg::segment_t seg_chain [N];
	isc_pkg::token_t   tok_chain [N];

	assign accept = start && !busy_q;

	// a new segment is pushed in at cell 0 and everything moves one cell along;
	// live segments always sit in cells below the stored count
	assign load_ok = accept && (request.kind == isc_pkg::KIND_LOAD)
		&& (request.seg_start <= request.seg_end)
		&& (stored_q < isc_pkg::SEG_CNT_W'(N));

	assign query_go = accept && (request.kind == isc_pkg::KIND_QUERY);

	assign seg_new.seg_start = request.seg_start;
	assign seg_new.seg_end   = request.seg_end;

	// token entering the row: remaining counts down the live cells still ahead
	assign tok_new.valid     = query_go;
	assign tok_new.point     = request.point;
	assign tok_new.remaining = stored_q;
	assign tok_new.hits      = '0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		if (i == 0) begin : g_head
			isc_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (load_ok),
				.seg_in   (seg_new),
				.seg_out  (seg_chain[i]),
				.tok_in   (tok_new),
				.tok_out  (tok_chain[i])
			);
		end else begin : g_body
			isc_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (load_ok),
				.seg_in   (seg_chain[i-1]),
				.seg_out  (seg_chain[i]),
				.tok_in   (tok_chain[i-1]),
				.tok_out  (tok_chain[i])
			);
		end
	end

	// store bookkeeping, query numbering and the sticky overflow bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q <= '0;
			query_q  <= '0;
			ovf_q    <= 1'b0;
			busy_q   <= 1'b0;
		end else begin
			if (accept) begin
				case (request.kind)
					isc_pkg::KIND_CLEAR: begin
						stored_q <= '0;
						query_q  <= '0;
						ovf_q    <= 1'b0;
					end
					isc_pkg::KIND_LOAD: begin
						if (request.seg_start <= request.seg_end) begin
							if (stored_q < isc_pkg::SEG_CNT_W'(N)) begin
								stored_q <= stored_q + 1'b1;
							end else begin
								ovf_q <= 1'b1;
							end
						end
					end
					isc_pkg::KIND_QUERY: begin
						if (query_q == isc_pkg::QRY_CNT_W'(isc_pkg::MAX_QUERIES - 1)) begin
							query_q <= '0;
						end else begin
							query_q <= query_q + 1'b1;
						end
					end
					default: begin
						// unused kind code: no effect
					end
				endcase
			end
			// held from acceptance until the token has left the last cell
			if (query_go) begin
				busy_q <= 1'b1;
			end else if (tok_chain[N-1].valid) begin
				busy_q <= 1'b0;
			end
		end
	end

	// index of the query in flight, frozen while busy
	always_ff @(posedge clk) begin
		if (query_go) begin
			qidx_q <= 16'(query_q);
		end
	end

	assign busy = busy_q;
	assign done = tok_chain[N-1].valid;

	assign result.cover_count = tok_chain[N-1].hits;
	assign result.point_index = qidx_q;
	assign result.overflowed  = ovf_q;

endmodule
